// File: hdl/fdcrf_pkg.sv
// ----------------------------------------------------------------------------
// fdcrf_pkg
// Shared types and constants for the floppy controller register file:
// bus windows, register selects, command codes and the head position record.
// ----------------------------------------------------------------------------
package fdcrf_pkg;

    // Bus windows: eight bytes each, bit 0 ignored inside a window
    localparam logic [15:0] READ_BASE  = 16'h5ff0;
    localparam logic [15:0] WRITE_BASE = 16'h5ff8;
    localparam logic [12:0] READ_WIN   = READ_BASE[15:3];
    localparam logic [12:0] WRITE_WIN  = WRITE_BASE[15:3];

    // Status and open-bus values
    localparam logic [7:0] STATUS_BASE = 8'h20;
    localparam logic [7:0] STATUS_TRK0 = 8'h04;
    localparam logic [7:0] OPEN_BUS    = 8'hff;
    localparam logic [7:0] TRACK_MAX   = 8'hff;

    // Register select from address bits 2..1
    typedef enum logic [1:0] {
        SEL_CMD_STATUS = 2'd0,
        SEL_TRACK      = 2'd1,
        SEL_SECTOR     = 2'd2,
        SEL_DATA       = 2'd3
    } reg_sel_t;

    // Command group from command bits 7..5
    typedef enum logic [2:0] {
        CMD_RESTORE  = 3'd0,
        CMD_STEP     = 3'd1,
        CMD_STEP_IN  = 3'd2,
        CMD_STEP_OUT = 3'd3,
        CMD_OTHER4   = 3'd4,
        CMD_OTHER5   = 3'd5,
        CMD_OTHER6   = 3'd6,
        CMD_OTHER7   = 3'd7
    } cmd_t;

    // Bit 4 of a command: update flag (seek flag for restore)
    localparam int UPDATE_BIT = 4;

    // Head position: track register and step direction
    typedef struct packed {
        logic [7:0] track;
        logic       step_inward;
    } head_t;

endpackage

// File: hdl/fdcrf_req_if.sv
// ----------------------------------------------------------------------------
// fdcrf_req_if
// Request channel: one bus access (read or write) with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fdcrf_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source
    (
        output valid,
        output action,
        output address,
        output write_data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  address,
        input  write_data,
        output ready
    );
endinterface

// File: hdl/fdcrf_rsp_if.sv
// ----------------------------------------------------------------------------
// fdcrf_rsp_if
// Response channel: the byte returned for one request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fdcrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source
    (
        output valid,
        output read_data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  read_data,
        output ready
    );
endinterface

// File: hdl/fdcrf_head.sv
// ----------------------------------------------------------------------------
// fdcrf_head
// Command decode for the head position: restore, seek and the three step
// commands, with the track saturating at 0 and 255.
// ----------------------------------------------------------------------------
module fdcrf_head
(
    input  logic [7:0]     command,
    input  logic [7:0]     data_val,
    input  fdcrf_pkg::head_t cur,
    output fdcrf_pkg::head_t nxt
);
    import fdcrf_pkg::*;

    logic       update;
    logic [7:0] track_in;
    logic [7:0] track_out;
    cmd_t       cmd;

    assign update = command[UPDATE_BIT];
    assign cmd    = cmd_t'(command[7:5]);

    // Saturating moves
    assign track_in  = (cur.track == TRACK_MAX) ? cur.track : cur.track + 8'd1;
    assign track_out = (cur.track == 8'd0)      ? cur.track : cur.track - 8'd1;

    // Select the new position per command group
    always_comb
    begin
        nxt = cur;
        unique case (cmd)
            CMD_RESTORE:
            begin
                nxt.track = update ? data_val : 8'd0;
            end
            CMD_STEP:
            begin
                if (update)
                begin
                    nxt.track = cur.step_inward ? track_in : track_out;
                end
            end
            CMD_STEP_IN:
            begin
                nxt.step_inward = 1'b1;
                if (update)
                begin
                    nxt.track = track_in;
                end
            end
            CMD_STEP_OUT:
            begin
                nxt.step_inward = 1'b0;
                if (update)
                begin
                    nxt.track = track_out;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: hdl/floppy_controller_register_file.sv
// ----------------------------------------------------------------------------
// floppy_controller_register_file
// Register side of a simplified floppy controller behind a CPU bus: status,
// track, sector and data reads; track, sector, data and command writes.
//
//   Channel | Dir | Payload                          | Handshake
//   --------+-----+----------------------------------+-------------
//   req     | in  | action, address[15:0], write_data| valid/ready
//   rsp     | out | read_data[7:0]                   | valid/ready
//
// One request per cycle sustained while rsp is not stalled; a request passes
// through the input register, then the result register, and its response is
// presented from the result register.
// Register updates take effect as the request leaves the input register, so
// each response sees all earlier writes.
// Reset clears the track, sector and data registers and the step direction.
// A stalled rsp holds the result; req accepts while the input register is
// empty or able to move on.
// ----------------------------------------------------------------------------
module floppy_controller_register_file
(
    input  logic        clk,
    input  logic        rst_n,
    fdcrf_req_if.sink   req,
    fdcrf_rsp_if.source rsp
);
    import fdcrf_pkg::*;

    // Input register
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_wdata_reg;

    // Result register
    logic        rsp_valid_reg;
    logic [7:0]  rsp_data_reg;

    // Controller state
    logic [7:0]  sector_reg;
    logic [7:0]  data_reg;
    head_t       head_reg;
    head_t       head_next;
    head_t       cmd_head;

    logic        advance;
    logic        accept;
    logic        in_write_win;
    logic        in_read_win;
    reg_sel_t    sel;
    logic [7:0]  status;
    logic [7:0]  result;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    // Address decode of the request in the input register
    assign in_write_win = (s1_address_reg[15:3] == WRITE_WIN);
    assign in_read_win  = (s1_address_reg[15:3] == READ_WIN);
    assign sel          = reg_sel_t'(s1_address_reg[2:1]);

    assign status = ~(STATUS_BASE | ((head_reg.track == 8'd0) ? STATUS_TRK0 : 8'd0));

    fdcrf_head u_head
    (
        .command  (s1_wdata_reg),
        .data_val (data_reg),
        .cur      (head_reg),
        .nxt      (cmd_head)
    );

    // Read result
    always_comb
    begin
        result = 8'd0;
        if (!s1_action_reg)
        begin
            if (s1_address_reg >= WRITE_BASE)
            begin
                result = OPEN_BUS;
            end
            else if (in_read_win)
            begin
                unique case (sel)
                    SEL_CMD_STATUS: result = status;
                    SEL_TRACK:      result = head_reg.track;
                    SEL_SECTOR:     result = sector_reg;
                    SEL_DATA:       result = data_reg;
                    default:        result = 8'd0;
                endcase
            end
        end
    end

    // Head position update for writes in the window
    always_comb
    begin
        head_next = head_reg;
        if (advance && s1_action_reg && in_write_win)
        begin
            unique case (sel)
                SEL_CMD_STATUS: head_next = cmd_head;
                SEL_TRACK:      head_next.track = s1_wdata_reg;
                default:        head_next = head_reg;
            endcase
        end
    end

    // Input register: take a request when empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg  <= req.action;
            s1_address_reg <= req.address;
            s1_wdata_reg   <= req.write_data;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp.ready)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg <= result;
        end
    end

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            sector_reg <= 8'd0;
            data_reg   <= 8'd0;
        end
        else
        begin
            head_reg <= head_next;
            if (advance && s1_action_reg && in_write_win)
            begin
                if (sel == SEL_SECTOR)
                begin
                    sector_reg <= s1_wdata_reg;
                end
                if (sel == SEL_DATA)
                begin
                    data_reg <= s1_wdata_reg;
                end
            end
        end
    end

endmodule

// File: hdl/fdcrf_check.sv
// ----------------------------------------------------------------------------
// fdcrf_check
// Port-level checks for the floppy controller register file, bound to the
// top level.
// ----------------------------------------------------------------------------
module fdcrf_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_action,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [7:0]  rsp_read_data
);
    logic req_acc;
    assign req_acc = req_valid && req_ready;

    // A stalled response holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
        else $error("stalled response changed");

    // No response right out of reset
    a_rsp_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid after reset");

    // Output stalled and a request just taken: input register full, no more
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_acc && rsp_valid && !rsp_ready) && $past(rst_n)
        && rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted with both stages full");

    // A write request returns a zero response when not stalled
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_acc && req_action, 2) && $past(rst_n, 2) && $past(rst_n)
        && $past(rsp_ready) |-> rsp_valid && (rsp_read_data == 8'd0))
        else $error("write response missing or nonzero");

endmodule

bind floppy_controller_register_file fdcrf_check u_fdcrf_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_action    (req.action),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data)
);

// File: sim/floppy_controller_register_file_test.sv
// ----------------------------------------------------------------------------
// floppy_controller_register_file_test
// Self-checking bench for the floppy controller register file. Drives bus
// reads and writes over the req channel, keeps its own copy of the track,
// sector, data and step direction registers to work out each returned byte,
// and compares every rsp byte in order. A directed pass covers the window
// edges, restore, seek, the step commands and track saturation. Random
// requests then run under four idling phases on both channels.
// ----------------------------------------------------------------------------
module floppy_controller_register_file_test;
    import fdcrf_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_ITEMS = 325;
    localparam int   REPORT_MAX   = 10;
    localparam int   DRAIN_CYCLES = 8;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } bus_access_t;

    // ------------------------------------------------------------------------
    // Register mirror and queue of expected read bytes
    // ------------------------------------------------------------------------
    class register_mirror;
        head_t      head;
        logic [7:0] sector;
        logic [7:0] data;
        logic [7:0] expected_bytes[$];
        int         errors;

        function void clear();
            head = '0;
            sector = '0;
            data = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Step the track one place, holding at both ends
        function void move_head(logic inward);
            if (inward && head.track != TRACK_MAX)
                head.track = head.track + 8'd1;
            else if (!inward && head.track != 8'd0)
                head.track = head.track - 8'd1;
        endfunction

        function void run_command(logic [7:0] code);
            logic upd;
            upd = code[UPDATE_BIT];
            case (cmd_t'(code[7:5]))
                CMD_RESTORE:  head.track = upd ? data : 8'd0;
                CMD_STEP:
                begin
                    if (upd)
                        move_head(head.step_inward);
                end
                CMD_STEP_IN:
                begin
                    head.step_inward = 1'b1;
                    if (upd)
                        move_head(1'b1);
                end
                CMD_STEP_OUT:
                begin
                    head.step_inward = 1'b0;
                    if (upd)
                        move_head(1'b0);
                end
                default: ;
            endcase
        endfunction

        function logic [7:0] bus_read(logic [15:0] addr);
            logic [7:0] status;
            if (addr >= WRITE_BASE)
                return OPEN_BUS;
            if (addr[15:3] != READ_WIN)
                return 8'd0;
            status = STATUS_BASE | ((head.track == 8'd0) ? STATUS_TRK0 : 8'd0);
            case (reg_sel_t'(addr[2:1]))
                SEL_CMD_STATUS: return ~status;
                SEL_TRACK:      return head.track;
                SEL_SECTOR:     return sector;
                default:        return data;
            endcase
        endfunction

        function void bus_write(logic [15:0] addr, logic [7:0] value);
            if (addr[15:3] != WRITE_WIN)
                return;
            case (reg_sel_t'(addr[2:1]))
                SEL_CMD_STATUS: run_command(value);
                SEL_TRACK:      head.track = value;
                SEL_SECTOR:     sector = value;
                default:        data = value;
            endcase
        endfunction

        // Apply an accepted request and queue the byte it returns
        function void note_request(bus_access_t acc);
            if (acc.action == ACT_WRITE)
            begin
                bus_write(acc.address, acc.write_data);
                expected_bytes.push_back(8'd0);
            end
            else
                expected_bytes.push_back(bus_read(acc.address));
        endfunction

        // Compare a returned byte with the oldest expectation
        function void check_response(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected response: read_data %02h with none pending", got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("read_data mismatch: expected %02h actual %02h", want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycles;
    int   sender_idle_pct;
    int   rsp_stall_pct;

    register_mirror mirror;

    fdcrf_req_if req_ch();
    fdcrf_rsp_if rsp_ch();

    floppy_controller_register_file DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Directed requests: window edges, restore, seek and step commands, saturation, ignored writes
    localparam bus_access_t DIRECTED [0:26] = '{
        {ACT_READ,  16'h5ff0, 8'h00},                        // status, track 0
        {ACT_READ,  16'h5ff1, 8'hff},
        {ACT_READ,  16'h0000, 8'h00},                        // below window
        {ACT_READ,  16'h5fef, 8'h00},
        {ACT_READ,  16'h5ff8, 8'h00},                        // above window
        {ACT_READ,  16'hffff, 8'h00},
        {ACT_WRITE, 16'h5ffa, 8'hff},                        // track to top
        {ACT_READ,  16'h5ff3, 8'h00},
        {ACT_READ,  16'h5ff0, 8'h00},                        // status, off track 0
        {ACT_WRITE, 16'h5ff8, {CMD_STEP_IN, 1'b1, 4'h0}},    // hold at 255
        {ACT_READ,  16'h5ff2, 8'h00},
        {ACT_WRITE, 16'h5ffd, 8'ha5},
        {ACT_WRITE, 16'h5fff, 8'h5a},
        {ACT_READ,  16'h5ff5, 8'h00},
        {ACT_READ,  16'h5ff7, 8'h00},
        {ACT_WRITE, 16'h5ff9, {CMD_RESTORE, 1'b1, 4'h0}},    // seek
        {ACT_WRITE, 16'h5ff8, {CMD_STEP_OUT, 1'b0, 4'h0}},   // direction only
        {ACT_WRITE, 16'h5ff8, {CMD_STEP, 1'b1, 4'h0}},
        {ACT_WRITE, 16'h5ff8, {CMD_STEP_IN, 1'b0, 4'hf}},    // direction only
        {ACT_WRITE, 16'h5ff8, {CMD_STEP, 1'b1, 4'hf}},
        {ACT_READ,  16'h5ff2, 8'h00},
        {ACT_WRITE, 16'h5ff8, {CMD_RESTORE, 1'b0, 4'hf}},    // restore
        {ACT_WRITE, 16'h5ff8, {CMD_STEP_OUT, 1'b1, 4'hf}},   // hold at 0
        {ACT_WRITE, 16'h5ff8, {CMD_OTHER4, 1'b0, 4'h0}},     // ignored
        {ACT_WRITE, 16'h5ff8, {CMD_OTHER7, 1'b1, 4'hf}},     // ignored
        {ACT_WRITE, 16'h5ff7, 8'h55},                        // below write window
        {ACT_READ,  16'h5ff2, 8'h00}
    };

    // ------------------------------------------------------------------------
    // Clock, cycle limit and response side
    // ------------------------------------------------------------------------
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("floppy_controller_register_file_test: errors");
            $finish;
        end
    end

    // Stall the response channel at the current rate
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Check each accepted response
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            mirror.check_response(rsp_ch.read_data);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Idle at random, present one request and hold it until accepted
    task automatic send_request(bus_access_t acc);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= acc.action;
        req_ch.address    <= acc.address;
        req_ch.write_data <= acc.write_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        mirror.note_request(acc);
    endtask

    // Track values biased toward both ends so stepping hits saturation
    function automatic logic [7:0] pick_track();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            3:       return TRACK_MAX;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return {cmd_t'($urandom_range(3)), 1'($urandom_range(1)), 4'($urandom_range(15))};
    endfunction

    // Mostly register window accesses, then window edges and bus noise
    task automatic random_request();
        bus_access_t acc;
        int          kind;
        kind = $urandom_range(99);
        acc.action = 1'($urandom_range(1));
        acc.write_data = 8'($urandom_range(255));
        if (kind < 65)
        begin
            acc.address = READ_BASE + 16'($urandom_range(15));
            if (acc.action == ACT_WRITE && acc.address[15:3] == WRITE_WIN)
            begin
                if (reg_sel_t'(acc.address[2:1]) == SEL_CMD_STATUS)
                    acc.write_data = pick_command();
                else if (reg_sel_t'(acc.address[2:1]) != SEL_SECTOR)
                    acc.write_data = pick_track();
            end
        end
        else if (kind < 80)
        begin
            case ($urandom_range(7))
                0:       acc.address = 16'h0000;
                1:       acc.address = 16'h5fef;
                2:       acc.address = 16'h5ff7;
                3:       acc.address = 16'h6000;
                4:       acc.address = 16'hffff;
                5:       acc.address = 16'h5ff0 - 16'($urandom_range(1, 16));
                6:       acc.address = 16'h5fff + 16'($urandom_range(1, 16));
                default: acc.address = 16'hdff0 + 16'($urandom_range(15));
            endcase
        end
        else
            acc.address = 16'($urandom_range(65535));
        send_request(acc);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mirror = new;
        mirror.clear();
        sender_idle_pct = 0;
        rsp_stall_pct = 0;
        rst_n <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_READ;
        req_ch.address    <= '0;
        req_ch.write_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_request(DIRECTED[i]);

        // Run the idling phases: none, sender, receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 30 : 0;
            rsp_stall_pct   = (phase == 2) ? 79 : (phase == 3) ? 30 : 0;
            for (int n = 0; n < RANDOM_ITEMS; n++)
                random_request();
        end

        // Drain outstanding responses, then watch for strays
        req_ch.valid <= 1'b0;
        rsp_stall_pct = 0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("floppy_controller_register_file_test: clean");
        else
            $display("floppy_controller_register_file_test: errors");
        $finish;
    end
endmodule

// File: files.f
hdl/fdcrf_pkg.sv
hdl/fdcrf_req_if.sv
hdl/fdcrf_rsp_if.sv
hdl/fdcrf_head.sv
hdl/floppy_controller_register_file.sv
hdl/fdcrf_check.sv
sim/floppy_controller_register_file_test.sv
